/* rtl/stcc_pkg.sv */
// ----------------------------------------------------------------------------
// stcc_pkg: shared types and constants
// Widths, default dimension limit and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stcc_pkg;

  localparam int DATA_W = 31;
  localparam int DEFAULT_MAX_DIMS = 7;

  typedef struct packed {
    logic do_final;
    logic set_fail;
    logic load;
    logic load_first;
    logic div_start;
    logic latch_quo;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic is_final;
    logic failed;
    logic dims_full;
    logic first;
    logic div_done;
    logic out_valid;
  } status_t;

endpackage

`default_nettype wire

/* rtl/strided_transfer_contiguity_check.sv */
// ----------------------------------------------------------------------------
// strided_transfer_contiguity_check: contiguity test for strided descriptors
// A dimension transaction after the first goes through accept, 31 divider steps
// of the bit-serial stride dividers, quotient latch and update; the first one
// goes through accept and update; final, failed, over-limit ones end at accept.
// A new transaction is taken only once the last is done and no result is stalled;
// the final flag is registered and valid in the cycle after accept.
// Synchronous reset clears all descriptor state and the pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module strided_transfer_contiguity_check #(
  parameter int MAX_DIMS = stcc_pkg::DEFAULT_MAX_DIMS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [stcc_pkg::DATA_W-1:0] src_pitch,
  input  wire logic [stcc_pkg::DATA_W-1:0] dst_pitch,
  input  wire logic [stcc_pkg::DATA_W-1:0] elem_count,
  input  wire logic                        is_final,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             contiguous
);

  stcc_pkg::cmd_t    cmd;
  stcc_pkg::status_t status;

  stcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  stcc_datapath #(.MAX_DIMS(MAX_DIMS)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .src_pitch  (src_pitch),
    .dst_pitch  (dst_pitch),
    .elem_count (elem_count),
    .is_final   (is_final),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .contiguous (contiguous)
  );

endmodule

`default_nettype wire

/* rtl/stcc_divider.sv */
// ----------------------------------------------------------------------------
// stcc_divider: iterative restoring divider
// One quotient bit per cycle; a zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stcc_divider #(
  parameter int W = stcc_pkg::DATA_W
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient
);

  localparam int CNT_W = $clog2(W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             qbit;

  assign trial = {rem, quo[W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= qbit ? diff[W-1:0] : trial[W-1:0];
      quo <= {quo[W-2:0], qbit};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

/* rtl/stcc_datapath.sv */
// ----------------------------------------------------------------------------
// stcc_datapath: descriptor state and arithmetic
// Holds strides, block length, gap and fail flags, two dividers, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stcc_datapath #(
  parameter int MAX_DIMS = stcc_pkg::DEFAULT_MAX_DIMS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire stcc_pkg::cmd_t              cmd,
  output stcc_pkg::status_t                status,
  input  wire logic [stcc_pkg::DATA_W-1:0] src_pitch,
  input  wire logic [stcc_pkg::DATA_W-1:0] dst_pitch,
  input  wire logic [stcc_pkg::DATA_W-1:0] elem_count,
  input  wire logic                        is_final,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             contiguous
);

  localparam int W = stcc_pkg::DATA_W;
  localparam int DIM_W = $clog2(MAX_DIMS + 1);
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIMS);

  logic [W-1:0]     prev_src_pitch;
  logic [W-1:0]     prev_dst_pitch;
  logic [W-1:0]     block_length;
  logic             gap_seen;
  logic             failed;
  logic [DIM_W-1:0] dims_seen;
  logic [W-1:0]     src_r;
  logic [W-1:0]     dst_r;
  logic [W-1:0]     cnt_r;
  logic [W-1:0]     src_ext;
  logic [W-1:0]     dst_ext;
  logic [W-1:0]     src_quo;
  logic [W-1:0]     dst_quo;
  logic             src_done;
  logic             dst_done;
  logic [2*W-1:0]   prod;
  logic             ovf;
  logic             is_short;
  logic             final_ok;

  stcc_divider #(.W(W)) u_div_src (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (src_pitch),
    .divisor  (prev_src_pitch),
    .done     (src_done),
    .quotient (src_quo)
  );

  stcc_divider #(.W(W)) u_div_dst (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dst_pitch),
    .divisor  (prev_dst_pitch),
    .done     (dst_done),
    .quotient (dst_quo)
  );

  assign prod     = {{W{1'b0}}, block_length} * {{W{1'b0}}, cnt_r};
  assign ovf      = |prod[2*W-1:W];
  assign is_short = (cnt_r < src_ext) || (cnt_r < dst_ext);
  assign final_ok = !failed &&
                    !(gap_seen && (dims_seen != '0) && (elem_count != W'(1)));

  always_comb begin
    status.is_final  = is_final;
    status.failed    = failed;
    status.dims_full = (dims_seen >= DIM_MAX);
    status.first     = (dims_seen == '0);
    status.div_done  = src_done;
    status.out_valid = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_src_pitch <= '0;
      prev_dst_pitch <= '0;
      block_length   <= W'(1);
      gap_seen       <= 1'b0;
      failed         <= 1'b0;
      dims_seen      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.do_final) begin
        out_valid <= 1'b0;
      end
      if (cmd.do_final) begin
        out_valid      <= 1'b1;
        prev_src_pitch <= '0;
        prev_dst_pitch <= '0;
        block_length   <= W'(1);
        gap_seen       <= 1'b0;
        failed         <= 1'b0;
        dims_seen      <= '0;
      end else if (cmd.set_fail) begin
        failed <= 1'b1;
      end else if (cmd.update) begin
        prev_src_pitch <= src_r;
        prev_dst_pitch <= dst_r;
        dims_seen      <= dims_seen + DIM_W'(1);
        if (ovf) begin
          failed <= 1'b1;
        end else begin
          block_length <= prod[W-1:0];
          priority if (is_short && gap_seen) begin
            failed <= 1'b1;
          end else if (is_short) begin
            gap_seen <= 1'b1;
          end else if ((cnt_r != W'(1)) && gap_seen) begin
            failed <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_final) begin
      contiguous <= final_ok;
    end
    if (cmd.load) begin
      src_r <= src_pitch;
      dst_r <= dst_pitch;
      cnt_r <= elem_count;
    end
    if (cmd.load_first) begin
      src_ext <= src_pitch;
      dst_ext <= dst_pitch;
    end else if (cmd.latch_quo && dst_done) begin
      src_ext <= src_quo;
      dst_ext <= dst_quo;
    end
  end

endmodule

`default_nettype wire

/* rtl/stcc_ctrl.sv */
// ----------------------------------------------------------------------------
// stcc_ctrl: sequencing state machine
// Classifies each accepted transaction and steps divide and update phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stcc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_ready,
  input  wire stcc_pkg::status_t status,
  output stcc_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && (!status.out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (status.is_final) begin
            cmd.do_final = 1'b1;
          end else if (status.failed) begin
            cmd = '0;
          end else if (status.dims_full) begin
            cmd.set_fail = 1'b1;
          end else if (status.first) begin
            cmd.load       = 1'b1;
            cmd.load_first = 1'b1;
            state_next     = S_UPD;
          end else begin
            cmd.load      = 1'b1;
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.latch_quo = 1'b1;
          state_next    = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* verif/stcc_checker.sv */
// ----------------------------------------------------------------------------
// stcc_checker: contiguity flag predictor and scoreboard
// Watches both channels of the contiguity check, folds every accepted
// dimension transaction into its own descriptor state and queues the flag
// that each final transaction must produce. Accepted results are compared in
// order against the queue. Mismatches and the number of flags still owed are
// reported to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stcc_checker #(
  parameter int MAX_DIMS = stcc_pkg::DEFAULT_MAX_DIMS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [stcc_pkg::DATA_W-1:0] src_pitch,
  input  logic [stcc_pkg::DATA_W-1:0] dst_pitch,
  input  logic [stcc_pkg::DATA_W-1:0] elem_count,
  input  logic                        is_final,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        contiguous,
  output int                          errors,
  output int                          pending
);

  localparam int DW = stcc_pkg::DATA_W;

  logic [DW-1:0] last_src;
  logic [DW-1:0] last_dst;
  logic [DW-1:0] run_len;
  logic          gap_open;
  logic          desc_bad;
  logic [3:0]    dim_cnt;
  bit            contig_expected[$];
  int            shown;

  initial begin
    errors = 0;
    pending = 0;
    shown = 0;
  end

  function automatic logic [DW-1:0] extent(input logic [DW-1:0] stride,
                                           input logic [DW-1:0] prev,
                                           input bit first);
    if (first) return stride;
    if (prev == '0) return '1;
    return stride / prev;
  endfunction

  task automatic clear_descriptor();
    last_src = '0;
    last_dst = '0;
    run_len = DW'(1);
    gap_open = 1'b0;
    desc_bad = 1'b0;
    dim_cnt = '0;
  endtask

  task automatic fold_transaction(input logic [DW-1:0] ss, input logic [DW-1:0] ds,
                                  input logic [DW-1:0] cnt, input logic fin);
    logic [63:0]   prod;
    logic [DW-1:0] sx;
    logic [DW-1:0] dx;
    bit            first;
    bit            narrow;
    bit            ok;
    if (fin) begin
      ok = !desc_bad;
      if (ok && gap_open && dim_cnt != 0 && cnt != 1) ok = 1'b0;
      contig_expected.push_back(ok);
      clear_descriptor();
    end else if (!desc_bad) begin
      if (dim_cnt >= MAX_DIMS) begin
        desc_bad = 1'b1;
      end else begin
        first = (dim_cnt == 0);
        sx = extent(ss, last_src, first);
        dx = extent(ds, last_dst, first);
        prod = 64'(run_len) * 64'(cnt);
        last_src = ss;
        last_dst = ds;
        dim_cnt = dim_cnt + 4'd1;
        if (prod > 64'h7fff_ffff) begin
          desc_bad = 1'b1;
        end else begin
          run_len = prod[DW-1:0];
          narrow = (cnt < sx) || (cnt < dx);
          if (narrow && gap_open) desc_bad = 1'b1;
          else if (narrow) gap_open = 1'b1;
          else if (cnt != 1 && gap_open) desc_bad = 1'b1;
        end
      end
    end
  endtask

  task automatic note_error(input string what, input bit exp, input bit act);
    errors = errors + 1;
    if (shown < 10) begin
      shown = shown + 1;
      $display("%0t ns: %s: expected %0b actual %0b", $time, what, exp, act);
    end
  endtask

  always @(posedge clk) begin
    bit exp;
    if (rst) begin
      clear_descriptor();
      contig_expected.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (contig_expected.size() == 0) begin
          note_error("contiguous result with nothing owed", 1'b0, contiguous);
        end else begin
          exp = contig_expected.pop_front();
          if (exp != contiguous) note_error("contiguous mismatch", exp, contiguous);
        end
      end
      if (in_valid && in_ready) fold_transaction(src_pitch, dst_pitch, elem_count, is_final);
    end
    pending = contig_expected.size();
  end

endmodule

/* verif/tb_strided_transfer_contiguity_check.sv */
// ----------------------------------------------------------------------------
// tb_strided_transfer_contiguity_check: testbench top
// Drives strided copy descriptors into the contiguity check: a directed set
// of corner descriptors, then random well-formed descriptors with and without
// a gap, broken and overflowing ones, over-long ones and raw noise. Both
// channels idle at random, and the receiver once holds off long enough to
// back the block up. A checker module predicts and compares the flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_strided_transfer_contiguity_check;

  localparam int DW = stcc_pkg::DATA_W;
  localparam int DIMS = stcc_pkg::DEFAULT_MAX_DIMS;
  localparam int TARGET_ITEMS = 1100;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  logic [DW-1:0] src_pitch;
  logic [DW-1:0] dst_pitch;
  logic [DW-1:0] elem_count;
  logic          is_final;
  logic          out_valid;
  logic          out_ready;
  logic          contiguous;
  int            errors;
  int            pending;

  int            sent = 0;
  bit            burst = 1'b0;
  bit            squeeze = 1'b0;
  bit            pressed = 1'b0;

  strided_transfer_contiguity_check #(.MAX_DIMS(DIMS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .src_pitch  (src_pitch),
    .dst_pitch  (dst_pitch),
    .elem_count (elem_count),
    .is_final   (is_final),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .contiguous (contiguous)
  );

  stcc_checker #(.MAX_DIMS(DIMS)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .src_pitch  (src_pitch),
    .dst_pitch  (dst_pitch),
    .elem_count (elem_count),
    .is_final   (is_final),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .contiguous (contiguous),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  task automatic send_item(input logic [DW-1:0] ss, input logic [DW-1:0] ds,
                           input logic [DW-1:0] cnt, input logic fin);
    int gap;
    bit taken;
    gap = (burst || squeeze) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    src_pitch <= ss;
    dst_pitch <= ds;
    elem_count <= cnt;
    is_final <= fin;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  task automatic random_descriptor();
    int            kind;
    int            nd;
    int            gdim;
    logic [63:0]   s;
    logic [63:0]   d;
    logic [DW-1:0] c;
    logic [DW-1:0] sx;
    logic [DW-1:0] dx;
    logic [DW-1:0] fc;
    kind = $urandom_range(0, 99);
    burst = ($urandom_range(0, 9) == 0);
    if (kind >= 95) begin
      send_item(DW'($urandom), DW'($urandom), DW'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    nd = (kind >= 90) ? DIMS + $urandom_range(1, 3) : $urandom_range(0, DIMS);
    gdim = (kind >= 50 && kind < 75 && nd > 0) ? $urandom_range(0, nd - 1) : -1;
    s = 64'd1;
    d = 64'd1;
    for (int i = 0; i < nd; i++) begin
      c = DW'($urandom_range(1, 12));
      sx = c;
      dx = c;
      if (kind >= 85 && kind < 90) begin
        c = DW'($urandom_range(32'h0000_8000, 32'h7fff_ffff));
        sx = DW'($urandom_range(1, 4));
        dx = sx;
      end else if (kind >= 75 && kind < 85) begin
        c = DW'($urandom_range(0, 16));
        sx = DW'($urandom_range(1, 16));
        dx = DW'($urandom_range(1, 16));
      end else if (gdim >= 0 && i == gdim) begin
        sx = c + DW'($urandom_range(1, 6));
        dx = $urandom_range(0, 1) ? sx : c;
      end else if (gdim >= 0 && i > gdim) begin
        c = DW'(1);
        sx = DW'(1);
        dx = DW'(1);
      end else if ($urandom_range(0, 3) == 0) begin
        sx = DW'($urandom_range(1, 32'(c)));
        dx = DW'($urandom_range(1, 32'(c)));
      end
      if (i == 0) begin
        s = 64'(sx);
        d = 64'(dx);
      end else begin
        // random remainder below the previous stride keeps the quotient
        s = s * 64'(sx) + ((s > 64'd1 && $urandom_range(0, 1) != 0) ?
                           64'($urandom_range(0, 32'(s - 64'd1))) : 64'd0);
        d = d * 64'(dx) + ((d > 64'd1 && $urandom_range(0, 1) != 0) ?
                           64'($urandom_range(0, 32'(d - 64'd1))) : 64'd0);
        s = s & 64'h7fff_ffff;
        d = d & 64'h7fff_ffff;
      end
      send_item(s[DW-1:0], d[DW-1:0], c, 1'b0);
    end
    if (gdim >= 0 && $urandom_range(0, 4) != 0) fc = DW'(1);
    else if ($urandom_range(0, 3) == 0) fc = DW'($urandom);
    else fc = DW'($urandom_range(0, 20));
    send_item(DW'($urandom), DW'($urandom), fc, 1'b1);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    src_pitch <= '0;
    dst_pitch <= '0;
    elem_count <= '0;
    is_final <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // final with no dimensions
    send_item('0, '0, '0, 1'b1);
    // plain contiguous two-dimensional copy
    send_item(31'd4, 31'd4, 31'd4, 1'b0);
    send_item(31'd32, 31'd32, 31'd8, 1'b0);
    send_item('1, '1, 31'd3, 1'b1);
    // one gap, final count of one
    send_item(31'd8, 31'd8, 31'd4, 1'b0);
    send_item('0, '0, 31'd1, 1'b1);
    // second short dimension
    send_item(31'd8, 31'd8, 31'd4, 1'b0);
    send_item(31'd64, 31'd64, 31'd2, 1'b0);
    send_item('0, '0, 31'd1, 1'b1);
    // product overflow, then a dimension that must be ignored
    send_item(31'd1, 31'd1, 31'h7fff_ffff, 1'b0);
    send_item(31'h7fff_ffff, 31'h7fff_ffff, 31'd2, 1'b0);
    send_item(31'd2, 31'd2, 31'd2, 1'b0);
    send_item('1, '0, 31'd1, 1'b1);
    // zero previous stride gives an all-ones extent
    send_item('0, '0, 31'd5, 1'b0);
    send_item(31'd7, 31'd7, 31'd1, 1'b0);
    send_item('0, '0, 31'd1, 1'b1);
    // more dimensions than the block supports
    for (int i = 0; i <= DIMS; i++) send_item(31'd1, 31'd1, 31'd1, 1'b0);
    send_item('0, '0, 31'd1, 1'b1);

    while (sent < TARGET_ITEMS) random_descriptor();

    burst = 1'b0;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!pressed && sent >= 500) begin
        pressed = 1'b1;
        squeeze = 1'b1;
        hold = 600;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        squeeze = 1'b0;
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 15) hold = gap_len();
      end
    end
  end

endmodule
